[rtl/pale_pkg.sv]
// ----------------------------------------------------------------------------
// pale_pkg: shared definitions for the positional array list engine
// Holds field widths, operation and status codes, and the result word type.
// ----------------------------------------------------------------------------
package pale_pkg;

  // Default list capacity.
  localparam int DEPTH_DEF = 64;

  // Field widths.
  localparam int OP_W  = 3;
  localparam int VAL_W = 32;
  localparam int POS_W = 7;
  localparam int ST_W  = 3;
  localparam int CNT_W = 7;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_START   = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND  = 3'd1;
  localparam logic [OP_W-1:0] OP_DISPLAY = 3'd2;
  localparam logic [OP_W-1:0] OP_INSERT  = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE  = 3'd4;
  localparam logic [OP_W-1:0] OP_SEARCH  = 3'd5;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [ST_W-1:0] ST_BADPOS   = 3'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

  // One result word.
  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] element;
    logic [POS_W-1:0]        found_at;
    logic [CNT_W-1:0]        element_count;
    logic                    last;
  } res_t;

endpackage

[rtl/pale_core.sv]
// ----------------------------------------------------------------------------
// pale_core: list storage and operation sequencer
// Holds the element memory and count, and walks the memory one entry per
// read/act pair for display, search, insert shifts and delete shifts.
// ----------------------------------------------------------------------------
module pale_core #(
  parameter int DEPTH = pale_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [pale_pkg::OP_W-1:0]      operation,
  input  logic signed [pale_pkg::VAL_W-1:0] value,
  input  logic [pale_pkg::POS_W-1:0]     position,
  output logic                           res_valid,
  input  logic                           res_ready,
  output pale_pkg::res_t                 res
);
  import pale_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_CHECK   = 8'b0000_0010,
    S_READ    = 8'b0000_0100,
    S_COMPARE = 8'b0000_1000,
    S_MOVE    = 8'b0001_0000,
    S_PLACE   = 8'b0010_0000,
    S_EMIT    = 8'b0100_0000,
    S_STREAM  = 8'b1000_0000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic [ST_W-1:0]      status_r, status_nxt;
  logic [POS_W-1:0]     found_r, found_nxt;
  logic [OP_W-1:0]      op_r;
  logic signed [VAL_W-1:0] val_r;
  logic [POS_W-1:0]     pos_r;

  // Element memory with one write port and one registered read port.
  logic signed [VAL_W-1:0] mem [DEPTH];
  logic signed [VAL_W-1:0] rd_data_r;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_wa, mem_ra;
  logic signed [VAL_W-1:0] mem_wd;

  logic [7:0] pos_x, cnt_x, idx_x;
  logic       stream_last;

  assign pos_x = {1'b0, pos_r};
  assign cnt_x = 8'(count_r);
  assign idx_x = 8'(idx_r);
  assign stream_last = (idx_x + 8'd1) == cnt_x;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  // Capture the input word when it is accepted.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r  <= operation;
      val_r <= value;
      pos_r <= position;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      idx_r    <= '0;
      status_r <= ST_OK;
      found_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      idx_r    <= idx_nxt;
      status_r <= status_nxt;
      found_r  <= found_nxt;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    mem_we     = 1'b0;
    mem_wa     = idx_r;
    mem_wd     = rd_data_r;
    mem_re     = 1'b0;
    mem_ra     = idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        status_nxt = ST_OK;
        found_nxt  = '0;
        state_nxt  = S_EMIT;
        idx_nxt    = '0;
        unique case (op_r)
          OP_START: begin
            count_nxt = '0;
          end
          OP_APPEND: begin
            if (cnt_x >= 8'(DEPTH)) begin
              status_nxt = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_wa    = AW'(count_r);
              mem_wd    = val_r;
              count_nxt = count_r + CW'(1);
            end
          end
          OP_DISPLAY, OP_SEARCH: begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              state_nxt = S_READ;
            end
          end
          OP_INSERT: begin
            priority if (count_r == '0) begin
              status_nxt = ST_EMPTY;
            end else if (cnt_x >= 8'(DEPTH)) begin
              status_nxt = ST_FULL;
            end else if (pos_x < 8'd1 || pos_x > cnt_x + 8'd1) begin
              status_nxt = ST_BADPOS;
            end else if (pos_x == cnt_x + 8'd1) begin
              state_nxt = S_PLACE;
            end else begin
              idx_nxt   = AW'(count_r);
              state_nxt = S_READ;
            end
          end
          OP_DELETE: begin
            priority if (count_r == '0) begin
              status_nxt = ST_EMPTY;
            end else if (pos_x < 8'd1 || pos_x > cnt_x) begin
              status_nxt = ST_BADPOS;
            end else if (pos_x == cnt_x) begin
              count_nxt = count_r - CW'(1);
            end else begin
              idx_nxt   = AW'(pos_r - 7'd1);
              state_nxt = S_READ;
            end
          end
          default: begin
            // Unused codes produce no result.
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_READ: begin
        mem_re = 1'b1;
        unique case (op_r)
          OP_INSERT: begin
            mem_ra    = idx_r - AW'(1);
            state_nxt = S_MOVE;
          end
          OP_DELETE: begin
            mem_ra    = idx_r + AW'(1);
            state_nxt = S_MOVE;
          end
          OP_DISPLAY: begin
            state_nxt = S_STREAM;
          end
          default: begin
            state_nxt = S_COMPARE;
          end
        endcase
      end

      S_COMPARE: begin
        priority if (rd_data_r == val_r) begin
          found_nxt = 7'(idx_r) + 7'd1;
          state_nxt = S_EMIT;
        end else if (stream_last) begin
          status_nxt = ST_NOTFOUND;
          state_nxt  = S_EMIT;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_READ;
        end
      end

      S_MOVE: begin
        mem_we = 1'b1;
        if (op_r == OP_INSERT) begin
          if (idx_x == pos_x) begin
            state_nxt = S_PLACE;
          end else begin
            idx_nxt   = idx_r - AW'(1);
            state_nxt = S_READ;
          end
        end else begin
          if (idx_x + 8'd2 >= cnt_x) begin
            count_nxt = count_r - CW'(1);
            state_nxt = S_EMIT;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = S_READ;
          end
        end
      end

      S_PLACE: begin
        mem_we    = 1'b1;
        mem_wa    = AW'(pos_r - 7'd1);
        mem_wd    = val_r;
        count_nxt = count_r + CW'(1);
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      S_STREAM: begin
        if (res_ready) begin
          if (stream_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = S_READ;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Handshake and result word.
  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_EMIT) || (state_r == S_STREAM);

  always_comb begin
    res.element_count = CNT_W'(count_r);
    if (state_r == S_STREAM) begin
      res.status   = ST_OK;
      res.element  = rd_data_r;
      res.found_at = '0;
      res.last     = stream_last;
    end else begin
      res.status   = status_r;
      res.element  = '0;
      res.found_at = found_r;
      res.last     = 1'b1;
    end
  end

  // The count never passes the capacity.
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_x <= 8'(DEPTH))
    else $error("element count exceeds capacity");

  // A start always reports an emptied list.
  a_start_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && op_r == OP_START) |-> count_r == '0)
    else $error("start did not empty the list");

  // Insert shifting never moves below the target position.
  a_insert_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE && op_r == OP_INSERT) |-> idx_x >= pos_x)
    else $error("insert shift went below target position");

  // A streamed element always lies inside the list.
  a_stream_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STREAM) |-> idx_x < cnt_x)
    else $error("display index outside the list");

  // An accepted word is checked in the next cycle.
  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == S_CHECK)
    else $error("accepted word was not dispatched");

endmodule

[rtl/positional_array_list_engine.sv]
// Start, append, last-element delete and every error result pass the check and
// emit states, then the output register. Search and shifting inserts and deletes
// pass a read and a compare or move state per element, an insert then a place
// state; display streams one element per read/stream pair while out_ready holds.
// Throughput: one word at a time; the next is taken once the last result is in
// the output register. Reset clears the count; memory is not cleared.
// ----------------------------------------------------------------------------
// positional_array_list_engine: ordered list with insert, delete and search
// Top level: the list sequencer followed by an output register stage.
// ----------------------------------------------------------------------------
module positional_array_list_engine #(
  parameter int DEPTH = pale_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pale_pkg::OP_W-1:0]         in_operation,
  input  logic signed [pale_pkg::VAL_W-1:0] in_value,
  input  logic [pale_pkg::POS_W-1:0]        in_position,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pale_pkg::ST_W-1:0]         out_status,
  output logic signed [pale_pkg::VAL_W-1:0] out_element,
  output logic [pale_pkg::POS_W-1:0]        out_found_at,
  output logic [pale_pkg::CNT_W-1:0]        out_element_count,
  output logic                              out_last
);
  import pale_pkg::*;

  logic res_valid, res_ready;
  res_t res, out_r;
  logic out_valid_r;

  pale_core #(
    .DEPTH(DEPTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (in_operation),
    .value     (in_value),
    .position  (in_position),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: loads a new word whenever it is empty or being drained.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_element       = out_r.element;
  assign out_found_at      = out_r.found_at;
  assign out_element_count = out_r.element_count;
  assign out_last          = out_r.last;

endmodule

[sim/tb_positional_array_list_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_array_list_engine: self-checking bench for the list engine
// Feeds list commands through a valid/ready driver with random idle bursts,
// predicts every result word from a behavioral copy of the list, and checks
// the returned words in order while the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb_positional_array_list_engine;
  import pale_pkg::*;

  localparam int LIST_DEPTH  = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RAND_CMDS   = 100;
  localparam int QUIET_TAIL  = 20;
  localparam int DRAIN_WAIT  = 300;

  // Codes the engine does not decode; they must be dropped silently.
  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
    bit                      drain;
  } list_cmd_t;

  logic                    clk          = 1'b0;
  logic                    rst_n        = 1'b0;
  logic                    in_valid     = 1'b0;
  logic                    in_ready;
  logic [OP_W-1:0]         in_operation = OP_START;
  logic signed [VAL_W-1:0] in_value     = '0;
  logic [POS_W-1:0]        in_position  = '0;
  logic                    out_valid;
  logic                    out_ready    = 1'b0;
  logic [ST_W-1:0]         out_status;
  logic signed [VAL_W-1:0] out_element;
  logic [POS_W-1:0]        out_found_at;
  logic [CNT_W-1:0]        out_element_count;
  logic                    out_last;

  list_cmd_t               pending_cmds[$];
  res_t                    expected_words[$];
  logic signed [VAL_W-1:0] list_mem [LIST_DEPTH];
  int                      list_len    = 0;
  int                      gen_len     = 0;
  int                      cmds_queued = 0;
  int                      words_sent  = 0;
  int                      words_taken = 0;
  int                      mismatches  = 0;
  int                      cycle_cnt   = 0;
  int                      send_gap    = 0;
  int                      stall_left  = 0;
  bit                      quiet       = 1'b0;
  list_cmd_t               next_cmd;
  res_t                    got;
  res_t                    want;

  always #5 clk = ~clk;

  positional_array_list_engine u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_value         (in_value),
    .in_position      (in_position),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_element      (out_element),
    .out_found_at     (out_found_at),
    .out_element_count(out_element_count),
    .out_last         (out_last)
  );

  // Queue one predicted result word; the count is the list length after the command.
  task automatic push_word(input logic [ST_W-1:0] status,
                           input logic signed [VAL_W-1:0] elem,
                           input int where, input bit is_last);
    res_t w;
    w.status        = status;
    w.element       = elem;
    w.found_at      = POS_W'(where);
    w.element_count = CNT_W'(list_len);
    w.last          = is_last;
    expected_words.push_back(w);
  endtask

  // Apply one accepted command to the behavioral list and queue its result words.
  task automatic predict_list_op(input logic [OP_W-1:0] op,
                                 input logic signed [VAL_W-1:0] value,
                                 input logic [POS_W-1:0] position);
    int pos;
    int i;
    int hit;
    pos = position;
    case (op)
      OP_START: begin
        list_len = 0;
        push_word(ST_OK, '0, 0, 1'b1);
      end
      OP_APPEND: begin
        if (list_len >= LIST_DEPTH) begin
          push_word(ST_FULL, '0, 0, 1'b1);
        end else begin
          list_mem[list_len] = value;
          list_len++;
          push_word(ST_OK, '0, 0, 1'b1);
        end
      end
      OP_DISPLAY: begin
        if (list_len == 0) begin
          push_word(ST_EMPTY, '0, 0, 1'b1);
        end else begin
          for (i = 0; i < list_len; i++)
            push_word(ST_OK, list_mem[i], 0, i == list_len - 1);
        end
      end
      OP_INSERT: begin
        // Empty is checked before full, full before the position.
        if (list_len == 0) begin
          push_word(ST_EMPTY, '0, 0, 1'b1);
        end else if (list_len >= LIST_DEPTH) begin
          push_word(ST_FULL, '0, 0, 1'b1);
        end else if (pos < 1 || pos > list_len + 1) begin
          push_word(ST_BADPOS, '0, 0, 1'b1);
        end else begin
          for (i = list_len; i >= pos; i--)
            list_mem[i] = list_mem[i-1];
          list_mem[pos-1] = value;
          list_len++;
          push_word(ST_OK, '0, 0, 1'b1);
        end
      end
      OP_DELETE: begin
        if (list_len == 0) begin
          push_word(ST_EMPTY, '0, 0, 1'b1);
        end else if (pos < 1 || pos > list_len) begin
          push_word(ST_BADPOS, '0, 0, 1'b1);
        end else begin
          for (i = pos - 1; i + 1 < list_len; i++)
            list_mem[i] = list_mem[i+1];
          list_len--;
          push_word(ST_OK, '0, 0, 1'b1);
        end
      end
      OP_SEARCH: begin
        if (list_len == 0) begin
          push_word(ST_EMPTY, '0, 0, 1'b1);
        end else begin
          hit = 0;
          for (i = 0; i < list_len && hit == 0; i++)
            if (list_mem[i] === value) hit = i + 1;
          if (hit != 0) push_word(ST_OK, '0, hit, 1'b1);
          else push_word(ST_NOTFOUND, '0, 0, 1'b1);
        end
      end
      default: begin
        // Undecoded codes leave the list alone and return nothing.
      end
    endcase
  endtask

  // Stimulus helpers.
  task automatic queue_cmd(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] value,
                           input int position, input bit drain);
    list_cmd_t c;
    c.op       = op;
    c.value    = value;
    c.position = POS_W'(position);
    c.drain    = drain;
    pending_cmds.push_back(c);
    if (op <= OP_SEARCH) cmds_queued++;
  endtask

  // Values come from the two extremes or from -3 to 3 two times in three so that searches hit.
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2, 3:    return VAL_W'($urandom_range(0, 6)) - 32'sd3;
      default: return $urandom();
    endcase
  endfunction

  // One random command; insert and delete positions run from zero to just past the list length.
  task automatic queue_random_op();
    int pick;
    int pos;
    logic [OP_W-1:0] op;
    pick = $urandom_range(0, 19);
    if (pick < 4) begin
      queue_cmd(OP_APPEND, pick_value(), $urandom_range(0, 127), 1'b0);
      if (gen_len < LIST_DEPTH) gen_len++;
    end else if (pick < 8) begin
      pos = $urandom_range(0, gen_len + 2);
      queue_cmd(OP_INSERT, pick_value(), pos, 1'b0);
      if (gen_len > 0 && gen_len < LIST_DEPTH && pos >= 1 && pos <= gen_len + 1) gen_len++;
    end else if (pick < 11) begin
      pos = $urandom_range(0, gen_len + 1);
      queue_cmd(OP_DELETE, $urandom(), pos, 1'b0);
      if (gen_len > 0 && pos >= 1 && pos <= gen_len) gen_len--;
    end else if (pick < 15) begin
      queue_cmd(OP_SEARCH, pick_value(), $urandom_range(0, 127), 1'b0);
    end else if (pick < 17) begin
      queue_cmd(OP_DISPLAY, $urandom(), $urandom_range(0, 127), 1'b0);
    end else if (pick == 17) begin
      queue_cmd(OP_START, $urandom(), $urandom_range(0, 127), 1'b0);
      gen_len = 0;
    end else begin
      // Noise: any code, any field value.
      op = OP_W'($urandom_range(0, 7));
      queue_cmd(op, $urandom(), $urandom_range(0, 127), 1'b0);
      if (op == OP_START) gen_len = 0;
    end
  endtask

  // Driver: presents one command word at a time, holding it until accepted.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && words_taken != words_sent) begin
        // Word still waiting for the handshake.
      end else if (send_gap > 0) begin
        send_gap = send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() != 0 &&
                   !(pending_cmds[0].drain && expected_words.size() != 0)) begin
        next_cmd = pending_cmds.pop_front();
        in_operation <= next_cmd.op;
        in_value     <= next_cmd.value;
        in_position  <= next_cmd.position;
        in_valid     <= 1'b1;
        words_sent++;
        if (!quiet && cycle_cnt[9:7] != 3'd0 && $urandom_range(0, 3) == 0)
          send_gap = $urandom_range(1, 18);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stalls out_ready in random bursts, never near the end.
  always @(negedge clk) begin
    if (!rst_n || quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (cycle_cnt[9:7] != 3'd0 && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: checks each result word against the oldest prediction, then
  // predicts the words of any command accepted at this edge.
  always @(posedge clk) begin
    quiet <= (pending_cmds.size() < QUIET_TAIL);
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.status        = out_status;
        got.element       = out_element;
        got.found_at      = out_found_at;
        got.element_count = out_element_count;
        got.last          = out_last;
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t: unexpected word status=%0d element=%0d found_at=%0d",
                      " count=%0d last=%0d"},
                     $time, got.status, got.element, got.found_at, got.element_count, got.last);
        end else begin
          want = expected_words.pop_front();
          if (got.status !== want.status || got.element !== want.element ||
              got.found_at !== want.found_at || got.element_count !== want.element_count ||
              got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: word mismatch", $time);
              $display("  expected status=%0d element=%0d found_at=%0d count=%0d last=%0d",
                       want.status, want.element, want.found_at, want.element_count, want.last);
              $display("  actual   status=%0d element=%0d found_at=%0d count=%0d last=%0d",
                       got.status, got.element, got.found_at, got.element_count, got.last);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        words_taken++;
        predict_list_op(in_operation, in_value, in_position);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int seq_idx;
    int n;
    int k;

    // Empty-list cases and undecoded codes right after reset.
    queue_cmd(OP_DISPLAY, '0, 0, 1'b0);
    queue_cmd(OP_INSERT, 32'sd7, 1, 1'b0);
    queue_cmd(OP_DELETE, '0, 1, 1'b0);
    queue_cmd(OP_SEARCH, '0, 0, 1'b0);
    queue_cmd(OP_RSVD6, -32'sd1, 127, 1'b0);
    queue_cmd(OP_RSVD7, '0, 0, 1'b0);
    // Build a list with both extremes and a repeated value.
    queue_cmd(OP_START, '0, 0, 1'b0);
    queue_cmd(OP_APPEND, VAL_MIN, 0, 1'b0);
    queue_cmd(OP_APPEND, VAL_MAX, 0, 1'b0);
    queue_cmd(OP_APPEND, '0, 0, 1'b0);
    queue_cmd(OP_APPEND, -32'sd1, 0, 1'b0);
    queue_cmd(OP_APPEND, VAL_MAX, 0, 1'b0);
    // Insert: position zero, past the end, all ones, then front and end.
    queue_cmd(OP_INSERT, 32'sd5, 0, 1'b0);
    queue_cmd(OP_INSERT, 32'sd5, 7, 1'b0);
    queue_cmd(OP_INSERT, 32'sd5, 127, 1'b0);
    queue_cmd(OP_INSERT, 32'sd11, 1, 1'b0);
    queue_cmd(OP_INSERT, 32'sd22, 7, 1'b0);
    // Delete: position zero, past the end, then front and last.
    queue_cmd(OP_DELETE, '0, 0, 1'b0);
    queue_cmd(OP_DELETE, '0, 8, 1'b0);
    queue_cmd(OP_DELETE, '0, 1, 1'b0);
    queue_cmd(OP_DELETE, '0, 6, 1'b0);
    // Search finds the first of the duplicates, then misses.
    queue_cmd(OP_SEARCH, VAL_MAX, 0, 1'b0);
    queue_cmd(OP_SEARCH, 32'sd12345, 0, 1'b0);
    queue_cmd(OP_DISPLAY, '0, 0, 1'b0);
    gen_len = 5;

    // Random sequences: start, a few appends, then mixed commands.
    cmds_queued = 0;
    seq_idx = 0;
    while (cmds_queued < RAND_CMDS) begin
      if (seq_idx == 2) begin
        // Fill to capacity after a full drain, then hit every full-list path.
        queue_cmd(OP_START, $urandom(), $urandom_range(0, 127), 1'b1);
        for (k = 0; k < LIST_DEPTH; k++)
          queue_cmd(OP_APPEND, pick_value(), $urandom_range(0, 127), 1'b0);
        queue_cmd(OP_APPEND, pick_value(), 0, 1'b0);
        queue_cmd(OP_INSERT, pick_value(), $urandom_range(1, LIST_DEPTH + 1), 1'b0);
        queue_cmd(OP_DISPLAY, $urandom(), 0, 1'b0);
        queue_cmd(OP_SEARCH, pick_value(), 0, 1'b0);
        queue_cmd(OP_DELETE, $urandom(), LIST_DEPTH + 1, 1'b0);
        queue_cmd(OP_DELETE, $urandom(), $urandom_range(1, LIST_DEPTH), 1'b0);
        queue_cmd(OP_INSERT, pick_value(), LIST_DEPTH, 1'b0);
        queue_cmd(OP_SEARCH, $urandom(), 0, 1'b0);
        gen_len = LIST_DEPTH;
      end else begin
        queue_cmd(OP_START, $urandom(), $urandom_range(0, 127), $urandom_range(0, 3) == 0);
        gen_len = 0;
        n = $urandom_range(0, 12);
        for (k = 0; k < n; k++) begin
          queue_cmd(OP_APPEND, pick_value(), $urandom_range(0, 127), 1'b0);
          gen_len++;
        end
        n = $urandom_range(3, 10);
        for (k = 0; k < n; k++)
          queue_random_op();
      end
      seq_idx++;
    end

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every command to be taken and every predicted word to return.
    while (pending_cmds.size() != 0 || words_taken != words_sent ||
           expected_words.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/pale_pkg.sv
rtl/pale_core.sv
rtl/positional_array_list_engine.sv
sim/tb_positional_array_list_engine.sv
